// File: src/nsv_pkg.sv
// Shared constants, codes and bundle types for the nearest-site Voronoi table.
// Used by nsv_cell and by the top level nearest_site_voronoi_table.
package nsv_pkg;

  // Table size and coordinate width
  localparam int MAX_SITES  = 64;
  localparam int COORD_BITS = 11;

  // Derived widths
  localparam int IDX_W   = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int CNT_W   = $clog2(MAX_SITES + 1);
  localparam int SQ_W    = 2 * COORD_BITS;
  localparam int DIST_W  = SQ_W + 1;
  localparam int COLOR_W = 32;
  localparam int RAD_W   = 8;
  localparam int R2_W    = 2 * RAD_W;
  localparam int CMP_W   = DIST_W + R2_W;

  // Result and configuration field widths
  localparam int OUT_IDX_W  = 6;
  localparam int OUT_CNT_W  = 7;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register reset values
  localparam logic [COLOR_W-1:0] BG_RESET     = COLOR_W'(255);
  localparam logic [RAD_W-1:0]   RADIUS_RESET = RAD_W'(5);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PICK_RADIUS = CFG_IDX_W'(1);

  // Command codes
  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_EDIT  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_SITE       = 3'd0,
    STAT_BACKGROUND = 3'd1,
    STAT_REMOVED    = 3'd2,
    STAT_APPENDED   = 3'd3,
    STAT_FULL       = 3'd4
  } status_e;

  // One stored site
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_W-1:0]    color;
  } site_t;

  // Running minimum that walks down the cell row
  typedef struct packed {
    logic               vld;
    logic               found;
    logic [DIST_W-1:0]  dsq;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] color;
  } tok_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic                  dist_en;
    logic                  shift_en;
    logic [IDX_W-1:0]      rem_idx;
    logic                  wr_en;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [COLOR_W-1:0]    color;
    logic [CNT_W-1:0]      count;
  } cell_ctrl_t;

endpackage

// File: src/nsv_cell.sv
// One cell of the site row: holds one site, its distance to the current
// position, and one stage of the running-minimum walk. Depends on nsv_pkg.
module nsv_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [nsv_pkg::IDX_W-1:0] cell_idx_i,
  input  nsv_pkg::cell_ctrl_t      ctrl_i,
  input  nsv_pkg::tok_t            tok_i,
  output nsv_pkg::tok_t            tok_o,
  input  nsv_pkg::site_t           next_site_i,
  output nsv_pkg::site_t           site_o
);
  import nsv_pkg::*;

  site_t             site_q;
  logic [DIST_W-1:0] dist_q;
  logic [DIST_W-1:0] dist_d;
  logic [COORD_BITS-1:0] dx, dy;
  logic [SQ_W-1:0]   sqx, sqy;
  logic              occ;
  logic              take;
  tok_t              tok_q;
  tok_t              tok_d;

  // Squared distance from the broadcast position
  always_comb begin
    dx     = (ctrl_i.px > site_q.x) ? (ctrl_i.px - site_q.x) : (site_q.x - ctrl_i.px);
    dy     = (ctrl_i.py > site_q.y) ? (ctrl_i.py - site_q.y) : (site_q.y - ctrl_i.py);
    sqx    = SQ_W'(dx) * SQ_W'(dx);
    sqy    = SQ_W'(dy) * SQ_W'(dy);
    dist_d = DIST_W'(sqx) + DIST_W'(sqy);
  end

  // Take over the minimum when occupied and strictly closer
  always_comb begin
    occ   = CNT_W'(cell_idx_i) < ctrl_i.count;
    take  = tok_i.vld && occ && (!tok_i.found || (dist_q < tok_i.dsq));
    tok_d = tok_i;
    if (take) begin
      tok_d.found = 1'b1;
      tok_d.dsq   = dist_q;
      tok_d.idx   = cell_idx_i;
      tok_d.color = site_q.color;
    end
  end

  // Advance the token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // Hold distance and site contents
  always_ff @(posedge clk_i) begin
    if (ctrl_i.dist_en) begin
      dist_q <= dist_d;
    end
    if (ctrl_i.shift_en && (cell_idx_i >= ctrl_i.rem_idx)) begin
      site_q <= next_site_i;
    end else if (ctrl_i.wr_en && (CNT_W'(cell_idx_i) == ctrl_i.count)) begin
      site_q.x     <= ctrl_i.px;
      site_q.y     <= ctrl_i.py;
      site_q.color <= ctrl_i.color;
    end
  end

  assign tok_o  = tok_q;
  assign site_o = site_q;

endmodule

// File: src/nearest_site_voronoi_table.sv
// Top level of the nearest-site Voronoi table: command sequencer, registers
// and a row of nsv_cell instances. Depends on nsv_pkg and nsv_cell.
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+-----------------------
//  command  | command_i pos_x_i pos_y_i new_color_i        | start high, busy low
//  result   | pixel_color_o site_index_o status_o          | result_valid_o, 1 cycle
//           | site_count_o                                 |
//  config   | cfg_index_i cfg_data_i                       | cfg_valid_i, cfg_ready_o
//
// Every command holds busy while all squared distances are formed in
// parallel (ST_DIST) and then the running minimum walks the cell row at
// one cell per cycle (ST_SCAN). The result strobe rises at the edge at
// which busy falls; in that cycle the next command may already be taken.
// Removal and append complete at the same edge that registers the result.
// Reset empties the table; the result side takes every beat without stalling.
module nearest_site_voronoi_table (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               command_i,
  input  logic [nsv_pkg::COORD_BITS-1:0]     pos_x_i,
  input  logic [nsv_pkg::COORD_BITS-1:0]     pos_y_i,
  input  logic [nsv_pkg::COLOR_W-1:0]        new_color_i,
  output logic                               result_valid_o,
  output logic [nsv_pkg::COLOR_W-1:0]        pixel_color_o,
  output logic [nsv_pkg::OUT_IDX_W-1:0]      site_index_o,
  output logic [nsv_pkg::STATUS_W-1:0]       status_o,
  output logic [nsv_pkg::OUT_CNT_W-1:0]      site_count_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [nsv_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [nsv_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import nsv_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIST,
    ST_SCAN
  } state_e;

  state_e                state_q;
  logic                  inj_q;
  logic                  cmd_q;
  logic [COORD_BITS-1:0] px_q, py_q;
  logic [COLOR_W-1:0]    ncol_q;
  logic [R2_W-1:0]       r2_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  done_q;
  logic [COLOR_W-1:0]    pcol_q;
  logic [IDX_W-1:0]      idx_q;
  status_e               stat_q;
  logic [COLOR_W-1:0]    bg_q;
  logic [RAD_W-1:0]      radius_q;

  cell_ctrl_t            ctrl;
  tok_t                  tok_w  [MAX_SITES+1];
  site_t                 site_w [MAX_SITES];
  tok_t                  tok_in;
  tok_t                  tok_end;
  logic                  fin;
  logic                  rem_go;
  logic                  app_go;
  logic                  accept;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Inject a fresh token into the head of the row
  always_comb begin
    tok_in     = '0;
    tok_in.vld = inj_q;
  end

  assign tok_w[0] = tok_in;
  assign tok_end  = tok_w[MAX_SITES];

  // Decide removal or append once the minimum leaves the row
  always_comb begin
    fin    = (state_q == ST_SCAN) && tok_end.vld;
    rem_go = fin && (cmd_q == CMD_EDIT) && tok_end.found &&
             (CMP_W'(tok_end.dsq) < CMP_W'(r2_q));
    app_go = fin && (cmd_q == CMD_EDIT) && !rem_go && (cnt_q < CNT_W'(MAX_SITES));
  end

  // Broadcast control to the cells
  always_comb begin
    ctrl.dist_en  = (state_q == ST_DIST);
    ctrl.shift_en = rem_go;
    ctrl.rem_idx  = tok_end.idx;
    ctrl.wr_en    = app_go;
    ctrl.px       = px_q;
    ctrl.py       = py_q;
    ctrl.color    = ncol_q;
    ctrl.count    = cnt_q;
  end

  // Row of site cells; on removal each cell at or above the removed index loads its upper neighbour
  for (genvar g = 0; g < MAX_SITES; g++) begin : g_cell
    site_t nxt;
    if (g == MAX_SITES - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = site_w[g+1];
    end
    nsv_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cell_idx_i  (IDX_W'(g)),
      .ctrl_i      (ctrl),
      .tok_i       (tok_w[g]),
      .tok_o       (tok_w[g+1]),
      .next_site_i (nxt),
      .site_o      (site_w[g])
    );
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q     <= BG_RESET;
      radius_q <= RADIUS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_BG_COLOR:    bg_q     <= cfg_data_i[COLOR_W-1:0];
        REG_PICK_RADIUS: radius_q <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state, site count and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      inj_q   <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      cmd_q   <= CMD_QUERY;
      px_q    <= '0;
      py_q    <= '0;
      ncol_q  <= '0;
      r2_q    <= '0;
      pcol_q  <= '0;
      idx_q   <= '0;
      stat_q  <= STAT_SITE;
    end else begin
      inj_q  <= 1'b0;
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cmd_q   <= command_i;
            px_q    <= pos_x_i;
            py_q    <= pos_y_i;
            ncol_q  <= new_color_i;
            state_q <= ST_DIST;
          end
        end
        ST_DIST: begin
          r2_q    <= R2_W'(radius_q) * R2_W'(radius_q);
          inj_q   <= 1'b1;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (fin) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
            pcol_q  <= '0;
            idx_q   <= '0;
            if (cmd_q == CMD_QUERY) begin
              if (tok_end.found) begin
                pcol_q <= tok_end.color;
                idx_q  <= tok_end.idx;
                stat_q <= STAT_SITE;
              end else begin
                pcol_q <= bg_q;
                stat_q <= STAT_BACKGROUND;
              end
            end else if (rem_go) begin
              idx_q  <= tok_end.idx;
              stat_q <= STAT_REMOVED;
              cnt_q  <= cnt_q - CNT_W'(1);
            end else if (app_go) begin
              idx_q  <= cnt_q[IDX_W-1:0];
              stat_q <= STAT_APPENDED;
              cnt_q  <= cnt_q + CNT_W'(1);
            end else begin
              stat_q <= STAT_FULL;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o = done_q;
  assign pixel_color_o  = pcol_q;
  assign site_index_o   = OUT_IDX_W'(idx_q);
  assign status_o       = stat_q;
  assign site_count_o   = OUT_CNT_W'(cnt_q);

  // The result strobe lasts one cycle
  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for more than one cycle");

  // The table never holds more than its capacity
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_SITES))
    else $error("site count beyond capacity");

  // The minimum only leaves the row during a scan
  a_tok_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_end.vld |-> (state_q == ST_SCAN))
    else $error("token left the row outside a scan");

  // A removal drops the count by one
  a_rem_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_go |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("removal did not decrement the count");

  // An append raises the count by one
  a_app_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    app_go |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("append did not increment the count");

endmodule
